### rtl/core/rtpc_pkg.sv
// Package for the RTP / network time converter.
// Shared types, constants and the cell payload struct; no dependencies.
package rtpc_pkg;

    localparam int NumStages = 64;
    localparam int DivWidth  = 84;
    localparam int RateWidth = 20;
    localparam logic [29:0] NsPerSec = 30'd1000000000;

    typedef enum logic [2:0] {
        REG_MAP_VALID = 3'd0,
        REG_SAMPLE_RATE = 3'd1,
        REG_ANCHOR_RTP = 3'd2,
        REG_ANCHOR_NET = 3'd3,
        REG_PLAYOUT_OFFSET = 3'd4
    } reg_index_t;

    typedef enum logic {
        CMD_RTP_TO_NET = 1'b0,
        CMD_NET_TO_RTP = 1'b1
    } command_t;

    // One beat travelling through the divider cells
    typedef struct packed {
        logic                 valid;
        logic                 ok;
        logic                 cmd;
        logic                 neg;
        logic [RateWidth-1:0] divisor;
        logic [DivWidth-1:0]  num;
        logic [63:0]          quo;
        logic [50:0]          rem;
        logic [63:0]          base;
        logic [31:0]          rtp_origin;
    } cell_beat_t;

endpackage

### rtl/core/rtpc_div_cell.sv
// One restoring-division cell: retires one quotient bit per cycle.
// Depends on rtpc_pkg.
module rtpc_div_cell
    import rtpc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cell_beat_t beat_in,
    output cell_beat_t beat_out
);

    cell_beat_t beat_reg;
    cell_beat_t beat_next;
    logic [51:0] trial;
    logic [51:0] dvs;

    // Shift in the next numerator bit and try a subtract
    always_comb
    begin
        beat_next = beat_in;
        dvs = beat_in.cmd ? {22'd0, NsPerSec} : {32'd0, beat_in.divisor};
        trial = {beat_in.rem, beat_in.num[DivWidth-1]};
        beat_next.num = {beat_in.num[DivWidth-2:0], 1'b0};
        if (trial >= dvs)
        begin
            beat_next.rem = 51'(trial - dvs);
            beat_next.quo = {beat_in.quo[62:0], 1'b1};
        end
        else
        begin
            beat_next.rem = trial[50:0];
            beat_next.quo = {beat_in.quo[62:0], 1'b0};
        end
    end

    // Advance one cell per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            beat_reg <= '0;
        else
            beat_reg <= beat_next;
    end

    assign beat_out = beat_reg;

endmodule

### rtl/core/rtp_network_time_converter.sv
// Top level of the RTP / network time converter.
// Depends on rtpc_pkg and rtpc_div_cell.

// Takes one command per cycle (busy is always low) and passes it through
// two front stages that form the magnitude and product, a chain of 64
// division cells that retire one quotient bit each, and one stage that
// applies sign and sum. The result strobe lasts one cycle and cannot be held off.
module rtp_network_time_converter
    import rtpc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        command,
    input  logic [31:0] rtp_stamp_in,
    input  logic signed [63:0] network_time_in,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data,
    output logic        done,
    output logic        ok,
    output logic signed [63:0] network_time_out,
    output logic [31:0] rtp_stamp_out
);

    logic        map_valid_reg;
    logic [19:0] sample_rate_reg;
    logic [31:0] rtp_origin_reg;
    logic [62:0] anchor_net_reg;
    logic [63:0] playout_offset_reg;

    assign busy = 1'b0;
    assign cfg_ready = 1'b1;

    // Write configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_valid_reg <= 1'b0;
            sample_rate_reg <= '0;
            rtp_origin_reg <= '0;
            anchor_net_reg <= '0;
            playout_offset_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_MAP_VALID:      map_valid_reg <= cfg_data[0];
                REG_SAMPLE_RATE:    sample_rate_reg <= cfg_data[19:0];
                REG_ANCHOR_RTP:     rtp_origin_reg <= cfg_data[31:0];
                REG_ANCHOR_NET:     anchor_net_reg <= cfg_data[62:0];
                REG_PLAYOUT_OFFSET: playout_offset_reg <= cfg_data;
                default:            ;
            endcase
        end
    end

    // Stage 1: differences and magnitude
    logic        s1_valid_reg;
    logic        s1_ok_reg;
    logic        s1_cmd_reg;
    logic        s1_neg_reg;
    logic [63:0] s1_mag_reg;
    logic [63:0] s1_base_reg;
    logic [31:0] s1_anchor_reg;
    logic [19:0] s1_rate_reg;
    logic [63:0] base_c;
    logic [63:0] delta_c;
    logic [31:0] drtp_c;
    logic        neg_c;

    always_comb
    begin
        base_c = {1'b0, anchor_net_reg} + playout_offset_reg;
        delta_c = network_time_in - base_c;
        drtp_c = rtp_stamp_in - rtp_origin_reg;
        if (command == CMD_RTP_TO_NET)
            neg_c = drtp_c[31];
        else
            neg_c = delta_c[63];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= start;
    end

    always_ff @(posedge clk)
    begin
        s1_ok_reg <= map_valid_reg && (sample_rate_reg != '0);
        s1_cmd_reg <= command;
        s1_neg_reg <= neg_c;
        s1_base_reg <= base_c;
        s1_anchor_reg <= rtp_origin_reg;
        s1_rate_reg <= sample_rate_reg;
        if (command == CMD_RTP_TO_NET)
            s1_mag_reg <= {32'd0, neg_c ? 32'(-drtp_c) : drtp_c};
        else
            s1_mag_reg <= neg_c ? 64'(-delta_c) : delta_c;
    end

    // Stage 2: product into the numerator (three 32-bit-sized multiplies)
    cell_beat_t  head;
    logic [83:0] prod_c;
    logic [51:0] plo_c;
    logic [51:0] phi_c;
    logic [61:0] pns_c;

    always_comb
    begin
        plo_c = {20'd0, s1_mag_reg[31:0]} * {32'd0, s1_rate_reg};
        phi_c = {20'd0, s1_mag_reg[63:32]} * {32'd0, s1_rate_reg};
        pns_c = {30'd0, s1_mag_reg[31:0]} * {32'd0, NsPerSec};
        if (s1_cmd_reg == CMD_RTP_TO_NET)
            prod_c = {22'd0, pns_c};
        else
            prod_c = {32'd0, plo_c} + {phi_c, 32'd0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            head <= '0;
        else
        begin
            head.valid <= s1_valid_reg;
            head.ok <= s1_ok_reg;
            head.cmd <= s1_cmd_reg;
            head.neg <= s1_neg_reg;
            head.divisor <= s1_rate_reg;
            head.num <= prod_c;
            head.quo <= '0;
            head.rem <= 51'(prod_c[83:64]);
            head.base <= s1_base_reg;
            head.rtp_origin <= s1_anchor_reg;
        end
    end

    // Chain of division cells, low 64 quotient bits
    cell_beat_t chain [NumStages+1];

    always_comb
    begin
        chain[0] = head;
        chain[0].num = {head.num[63:0], 20'd0};
    end

    // Upper 20 bits preload the remainder; cells walk the low 64
    for (genvar i = 0; i < NumStages; i++)
    begin : g_cell
        rtpc_div_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .beat_in  (chain[i]),
            .beat_out (chain[i+1])
        );
    end

    // Final stage: sign and sums
    cell_beat_t tail;
    logic [63:0] q_signed_c;
    logic [31:0] q32_c;

    assign tail = chain[NumStages];

    always_comb
    begin
        q_signed_c = tail.neg ? 64'(-tail.quo) : tail.quo;
        q32_c = tail.neg ? 32'(-tail.quo[31:0]) : tail.quo[31:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done <= 1'b0;
        else
            done <= tail.valid;
    end

    always_ff @(posedge clk)
    begin
        ok <= tail.ok;
        network_time_out <= '0;
        rtp_stamp_out <= '0;
        if (tail.ok)
        begin
            if (tail.cmd == CMD_RTP_TO_NET)
                network_time_out <= tail.base + q_signed_c;
            else
                rtp_stamp_out <= tail.rtp_origin + q32_c;
        end
    end

`ifndef SYNTHESIS
    // Every accepted command yields a strobe after the full latency
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##(NumStages + 3) done)
        else $error("result strobe missing");
    // A failed conversion leaves both outputs zero
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !ok) |-> (network_time_out == '0 && rtp_stamp_out == '0))
        else $error("failed conversion drives nonzero output");
    // No strobe without a command in flight
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(tail.valid))
        else $error("spurious result strobe");
`endif

endmodule

### verif/rtp_network_time_converter_tb.sv
// Testbench for the RTP / network time converter: directed table, then random phases.
// Depends on rtpc_pkg and the rtp_network_time_converter RTL with its rtpc_div_cell.
`timescale 1ns / 100ps

module rtp_network_time_converter_tb
    import rtpc_pkg::*;
;

    localparam logic [2:0]  RegUnused   = 3'd7;
    localparam int          DrainCycles = 80;
    localparam int          PhaseItems  = 48;
    localparam int          NumPhases   = 8;

    typedef enum logic { ROW_CFG, ROW_ITEM } row_kind_t;

    typedef struct {
        row_kind_t   kind;
        logic [2:0]  cfg_idx;
        logic [63:0] cfg_val;
        logic        cmd;
        logic [31:0] rtp;
        logic [63:0] net;
        logic        typed;
        logic        exp_ok;
        logic [63:0] exp_net;
        logic [31:0] exp_rtp;
    } step_row_t;

    typedef struct packed {
        logic        ok;
        logic [63:0] net;
        logic [31:0] rtp;
    } conv_result_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic               command;
    logic [31:0]        rtp_stamp_in;
    logic signed [63:0] network_time_in;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [2:0]         cfg_index;
    logic [63:0]        cfg_data;
    logic               done;
    logic               ok;
    logic signed [63:0] network_time_out;
    logic [31:0]        rtp_stamp_out;

    // Mirror of the map registers
    logic        map_valid_m;
    logic [19:0] rate_m;
    logic [31:0] rtp_origin_m;
    logic [62:0] anchor_net_m;
    logic [63:0] offset_m;

    conv_result_t pending_results[$];
    int           error_count;
    bit           no_idle;

    rtp_network_time_converter i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .command          (command),
        .rtp_stamp_in     (rtp_stamp_in),
        .network_time_in  (network_time_in),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .done             (done),
        .ok               (ok),
        .network_time_out (network_time_out),
        .rtp_stamp_out    (rtp_stamp_out)
    );

    // Directed stimulus: anchor 1000 / 5e9 ns, offset -1000 ns, 48 kHz
    step_row_t directed_rows [] = '{
        '{ROW_ITEM, 3'd0, 64'd0, CMD_RTP_TO_NET, 32'd1000, 64'd0, 1'b1, 1'b0, 64'd0, 32'd0},
        '{ROW_ITEM, 3'd0, 64'd0, CMD_NET_TO_RTP, 32'd0, 64'd5000000000, 1'b1, 1'b0, 64'd0, 32'd0},
        '{ROW_CFG, REG_MAP_VALID, 64'd1, 1'b0, 32'd0, 64'd0, 1'b0, 1'b0, 64'd0, 32'd0},
        '{ROW_ITEM, 3'd0, 64'd0, CMD_RTP_TO_NET, 32'hFFFFFFFF, 64'd0, 1'b1, 1'b0, 64'd0, 32'd0},
        '{ROW_ITEM, 3'd0, 64'd0, CMD_NET_TO_RTP, 32'd0, 64'd1, 1'b1, 1'b0, 64'd0, 32'd0},
        '{ROW_CFG, REG_SAMPLE_RATE, 64'd48000, 1'b0, 32'd0, 64'd0, 1'b0, 1'b0, 64'd0, 32'd0},
        '{ROW_CFG, REG_ANCHOR_RTP, 64'd1000, 1'b0, 32'd0, 64'd0, 1'b0, 1'b0, 64'd0, 32'd0},
        '{ROW_CFG, REG_ANCHOR_NET, 64'd5000000000, 1'b0, 32'd0, 64'd0, 1'b0, 1'b0, 64'd0, 32'd0},
        '{ROW_CFG, REG_PLAYOUT_OFFSET, -64'sd1000, 1'b0, 32'd0, 64'd0, 1'b0, 1'b0, 64'd0,
          32'd0},
        '{ROW_ITEM, 3'd0, 64'd0, CMD_RTP_TO_NET, 32'd1000, 64'd0, 1'b1, 1'b1, 64'd4999999000,
          32'd0},
        '{ROW_ITEM, 3'd0, 64'd0, CMD_NET_TO_RTP, 32'd0, 64'd4999999000, 1'b1, 1'b1, 64'd0,
          32'd1000},
        '{ROW_ITEM, 3'd0, 64'd0, CMD_RTP_TO_NET, 32'd49000, 64'd0, 1'b1, 1'b1, 64'd5999999000,
          32'd0},
        '{ROW_ITEM, 3'd0, 64'd0, CMD_RTP_TO_NET, 32'd0, 64'd0, 1'b0, 1'b0, 64'd0, 32'd0},
        '{ROW_ITEM, 3'd0, 64'd0, CMD_RTP_TO_NET, 32'h800003E8, 64'd0, 1'b0, 1'b0, 64'd0, 32'd0},
        '{ROW_ITEM, 3'd0, 64'd0, CMD_NET_TO_RTP, 32'd0, 64'h8000000000000000, 1'b0, 1'b0,
          64'd0, 32'd0},
        '{ROW_ITEM, 3'd0, 64'd0, CMD_NET_TO_RTP, 32'd0, 64'h7FFFFFFFFFFFFFFF, 1'b0, 1'b0,
          64'd0, 32'd0},
        '{ROW_CFG, REG_SAMPLE_RATE, 64'hFFFFF, 1'b0, 32'd0, 64'd0, 1'b0, 1'b0, 64'd0, 32'd0},
        '{ROW_CFG, REG_ANCHOR_NET, 64'h7FFFFFFFFFFFFFFF, 1'b0, 32'd0, 64'd0, 1'b0, 1'b0, 64'd0,
          32'd0},
        '{ROW_CFG, REG_PLAYOUT_OFFSET, 64'h7FFFFFFFFFFFFFFF, 1'b0, 32'd0, 64'd0, 1'b0, 1'b0,
          64'd0, 32'd0},
        '{ROW_CFG, RegUnused, 64'hFFFFFFFFFFFFFFFF, 1'b0, 32'd0, 64'd0, 1'b0, 1'b0, 64'd0,
          32'd0},
        '{ROW_ITEM, 3'd0, 64'd0, CMD_RTP_TO_NET, 32'h7FFFFFFF, 64'd0, 1'b0, 1'b0, 64'd0, 32'd0},
        '{ROW_ITEM, 3'd0, 64'd0, CMD_NET_TO_RTP, 32'd0, 64'h8000000000000000, 1'b0, 1'b0,
          64'd0, 32'd0},
        '{ROW_CFG, REG_SAMPLE_RATE, 64'd1, 1'b0, 32'd0, 64'd0, 1'b0, 1'b0, 64'd0, 32'd0},
        '{ROW_CFG, REG_PLAYOUT_OFFSET, 64'h8000000000000000, 1'b0, 32'd0, 64'd0, 1'b0, 1'b0,
          64'd0, 32'd0},
        '{ROW_ITEM, 3'd0, 64'd0, CMD_RTP_TO_NET, 32'h80000000, 64'd0, 1'b0, 1'b0, 64'd0, 32'd0},
        '{ROW_ITEM, 3'd0, 64'd0, CMD_NET_TO_RTP, 32'd0, 64'hFFFFFFFFFFFFFFFF, 1'b0, 1'b0,
          64'd0, 32'd0}
    };

    // Expected result of one conversion under the mirrored map
    function automatic conv_result_t predict_conversion(logic cmd, logic [31:0] rtp,
                                                        logic [63:0] net);
        conv_result_t       res;
        logic [63:0]        base;
        logic [63:0]        delta;
        logic [63:0]        mag;
        logic [31:0]        rtp_diff;
        logic signed [63:0] rtp_diff_s;
        logic signed [63:0] diff_ns;
        logic [83:0]        scaled;
        logic [31:0]        samples;
        res  = '0;
        base = {1'b0, anchor_net_m} + offset_m;
        if (!map_valid_m || rate_m == 20'd0)
            return res;
        res.ok = 1'b1;
        if (cmd == CMD_RTP_TO_NET)
        begin
            rtp_diff   = rtp - rtp_origin_m;
            rtp_diff_s = {{32{rtp_diff[31]}}, rtp_diff};
            diff_ns    = (rtp_diff_s * 64'sd1000000000) / $signed({44'd0, rate_m});
            res.net    = base + diff_ns;
        end
        else
        begin
            delta   = net - base;
            mag     = delta[63] ? -delta : delta;
            scaled  = ({20'd0, mag} * {64'd0, rate_m}) / 84'd1000000000;
            samples = scaled[31:0];
            if (delta[63])
                samples = -samples;
            res.rtp = rtp_origin_m + samples;
        end
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("MISMATCH %s: got 0x%h, expected 0x%h at %0t", what, got, want, $time);
        error_count++;
    endtask

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Run limit
    initial
    begin
        #2ms;
        $display("Some tests failed");
        $finish;
    end

    // Check every result beat against the oldest expectation
    always @(posedge clk)
    begin
        conv_result_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
                report_mismatch("unexpected result", {63'd0, ok}, 64'd0);
            else
            begin
                want = pending_results.pop_front();
                if (ok !== want.ok)
                    report_mismatch("ok", {63'd0, ok}, {63'd0, want.ok});
                if (network_time_out !== want.net)
                    report_mismatch("network_time_out", network_time_out, want.net);
                if (rtp_stamp_out !== want.rtp)
                    report_mismatch("rtp_stamp_out", {32'd0, rtp_stamp_out}, {32'd0, want.rtp});
            end
        end
    end

    task automatic wait_drained();
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Write one register once the block has no work in flight
    task automatic write_register(logic [2:0] idx, logic [63:0] value);
        wait_drained();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_MAP_VALID:      map_valid_m  = value[0];
            REG_SAMPLE_RATE:    rate_m       = value[19:0];
            REG_ANCHOR_RTP:     rtp_origin_m = value[31:0];
            REG_ANCHOR_NET:     anchor_net_m = value[62:0];
            REG_PLAYOUT_OFFSET: offset_m     = value;
            default:            ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Send one command beat after a random gap (none when no_idle is set); hold start across back-to-back beats
    task automatic send_command(logic cmd, logic [31:0] rtp, logic [63:0] net,
                                bit typed, conv_result_t typed_result);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 9);
        repeat (gap)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
        @(negedge clk);
        start           <= 1'b1;
        command         <= cmd;
        rtp_stamp_in    <= rtp;
        network_time_in <= net;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_results.push_back(typed ? typed_result : predict_conversion(cmd, rtp, net));
    endtask

    task automatic release_start();
        @(negedge clk);
        start <= 1'b0;
    endtask

    // Load a map for one random phase; the first phases hit the extremes
    task automatic load_map(int phase);
        logic [63:0] rate_v;
        logic [63:0] net_v;
        logic [63:0] off_v;
        rate_v = $urandom_range(1, 20'hFFFFF);
        net_v  = {$urandom, $urandom};
        off_v  = {$urandom, $urandom};
        if ($urandom_range(0, 1))
            off_v = {{40{off_v[23]}}, off_v[23:0]};
        case (phase)
            1:       begin rate_v = 64'd1;     off_v = 64'h8000000000000000; end
            2:       begin rate_v = 64'hFFFFF; net_v = 64'h7FFFFFFFFFFFFFFF;
                           off_v = 64'h7FFFFFFFFFFFFFFF; end
            3:       begin rate_v = 64'd0; end
            4:       begin rate_v = 64'd44100; net_v = 64'd0; off_v = 64'd0; end
            default: ;
        endcase
        write_register(REG_MAP_VALID, {63'd0, phase != 5});
        write_register(REG_SAMPLE_RATE, rate_v);
        write_register(REG_ANCHOR_RTP, {32'd0, $urandom});
        write_register(REG_ANCHOR_NET, net_v);
        write_register(REG_PLAYOUT_OFFSET, off_v);
    endtask

    initial
    begin
        conv_result_t typed_result;
        logic         cmd;
        logic [31:0]  rtp;
        logic [63:0]  net;
        logic [63:0]  base;
        int           spread;

        error_count     = 0;
        no_idle         = 1'b0;
        map_valid_m     = 1'b0;
        rate_m          = '0;
        rtp_origin_m    = '0;
        anchor_net_m    = '0;
        offset_m        = '0;
        rst_n           = 1'b0;
        start           = 1'b0;
        command         = CMD_RTP_TO_NET;
        rtp_stamp_in    = '0;
        network_time_in = '0;
        cfg_valid       = 1'b0;
        cfg_index       = REG_MAP_VALID;
        cfg_data        = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Walk the directed table
        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_CFG)
            begin
                release_start();
                write_register(directed_rows[i].cfg_idx, directed_rows[i].cfg_val);
            end
            else
            begin
                typed_result.ok  = directed_rows[i].exp_ok;
                typed_result.net = directed_rows[i].exp_net;
                typed_result.rtp = directed_rows[i].exp_rtp;
                send_command(directed_rows[i].cmd, directed_rows[i].rtp, directed_rows[i].net,
                             directed_rows[i].typed, typed_result);
            end
        end
        release_start();

        // Random phases, each under a fresh map
        for (int phase = 1; phase <= NumPhases; phase++)
        begin
            load_map(phase);
            no_idle = (phase % 3 == 0);
            base    = {1'b0, anchor_net_m} + offset_m;
            for (int n = 0; n < PhaseItems; n++)
            begin
                cmd    = $urandom_range(0, 1);
                spread = $urandom_range(0, 3);
                // Mostly conversions near the anchor, some across the whole range
                if (spread == 0)
                begin
                    rtp = $urandom;
                    net = {$urandom, $urandom};
                end
                else
                begin
                    rtp = rtp_origin_m + ($urandom_range(0, 400000) - 200000);
                    net = base + {{32{1'b0}}, $urandom} - 64'd2147483648;
                    if (spread == 3)
                        net = base + {{22{1'b0}}, $urandom, 10'd0} - 64'h0000020000000000;
                end
                send_command(cmd, rtp, net, 1'b0, typed_result);
            end
            release_start();
        end

        // Drain and let the pipeline settle
        wait_drained();
        repeat (DrainCycles) @(posedge clk);
        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

### filelist.f
rtl/core/rtpc_pkg.sv
rtl/core/rtpc_div_cell.sv
rtl/core/rtp_network_time_converter.sv
verif/rtp_network_time_converter_tb.sv
